/* hdl/kplrs_pkg.sv */
// ----------------------------------------------------------------------------
// kplrs_pkg
// Shared widths, register indexes and types for the key press scanner.
// ----------------------------------------------------------------------------
package kplrs_pkg;

    localparam int NUM_KEYS   = 3;
    localparam int TIME_W     = 32;
    localparam int MS_W       = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS_MS      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_INTERVAL_MS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_ENABLE_MASK = 2'd2;

    localparam logic [MS_W-1:0]     LONG_PRESS_RST      = 16'd1000;
    localparam logic [MS_W-1:0]     REPEAT_INTERVAL_RST = 16'd200;
    localparam logic [NUM_KEYS-1:0] REPEAT_ENABLE_RST   = NUM_KEYS'(3'd6);

    typedef struct packed {
        logic [MS_W-1:0]     long_press_ms;
        logic [MS_W-1:0]     repeat_interval_ms;
        logic [NUM_KEYS-1:0] repeat_enable_mask;
    } t_cfg;

    typedef struct packed {
        logic fire;
        logic held;
        logic level;
    } t_key_res;

endpackage

/* hdl/kplrs_intf.sv */
// ----------------------------------------------------------------------------
// kplrs interfaces
// Scan input, result output and register write channels.
// ----------------------------------------------------------------------------
interface kplrs_in_if;
    logic                           valid;
    logic                           ready;
    logic [kplrs_pkg::NUM_KEYS-1:0] key_levels;
    logic [kplrs_pkg::TIME_W-1:0]   now_ms;

    modport source (output valid, output key_levels, output now_ms, input ready);
    modport sink   (input valid, input key_levels, input now_ms, output ready);
endinterface

interface kplrs_out_if;
    logic                           valid;
    logic                           ready;
    logic [kplrs_pkg::NUM_KEYS-1:0] press_mask;
    logic [kplrs_pkg::NUM_KEYS-1:0] held_fire_mask;
    logic [kplrs_pkg::NUM_KEYS-1:0] stable_levels;

    modport source (output valid, output press_mask, output held_fire_mask,
                    output stable_levels, input ready);
    modport sink   (input valid, input press_mask, input held_fire_mask,
                    input stable_levels, output ready);
endinterface

interface kplrs_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [kplrs_pkg::CFG_IDX_W-1:0]  index;
    logic [kplrs_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* hdl/kplrs_cfg_regs.sv */
// ----------------------------------------------------------------------------
// kplrs_cfg_regs
// Configuration register file: long-press time, repeat interval, enables.
// ----------------------------------------------------------------------------
module kplrs_cfg_regs (
    input  logic               i_clk,
    input  logic               i_rst_n,
    kplrs_cfg_if.sink          i_cfg,
    output kplrs_pkg::t_cfg    o_cfg
);

    kplrs_pkg::t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.long_press_ms      <= kplrs_pkg::LONG_PRESS_RST;
            r_cfg.repeat_interval_ms <= kplrs_pkg::REPEAT_INTERVAL_RST;
            r_cfg.repeat_enable_mask <= kplrs_pkg::REPEAT_ENABLE_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                kplrs_pkg::CFG_LONG_PRESS_MS: begin
                    r_cfg.long_press_ms <= i_cfg.data[kplrs_pkg::MS_W-1:0];
                end
                kplrs_pkg::CFG_REPEAT_INTERVAL_MS: begin
                    r_cfg.repeat_interval_ms <= i_cfg.data[kplrs_pkg::MS_W-1:0];
                end
                kplrs_pkg::CFG_REPEAT_ENABLE_MASK: begin
                    r_cfg.repeat_enable_mask <= i_cfg.data[kplrs_pkg::NUM_KEYS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

endmodule

/* hdl/kplrs_key_cell.sv */
// ----------------------------------------------------------------------------
// kplrs_key_cell
// Per-key state and press, long-press and auto-repeat decision.
// ----------------------------------------------------------------------------
module kplrs_key_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic                          i_level,
    input  logic [kplrs_pkg::TIME_W-1:0]  i_now_ms,
    input  logic                          i_enable,
    input  logic [kplrs_pkg::MS_W-1:0]    i_long_press_ms,
    input  logic [kplrs_pkg::MS_W-1:0]    i_repeat_interval_ms,
    output kplrs_pkg::t_key_res           o_res
);

    logic                         r_stable;
    logic                         r_long;
    logic [kplrs_pkg::TIME_W-1:0] r_mark;
    logic                         n_long;
    logic [kplrs_pkg::TIME_W-1:0] n_mark;
    logic                         w_changed;
    logic                         w_low;
    logic [kplrs_pkg::TIME_W-1:0] w_elapsed;

    assign w_low     = !i_level;
    assign w_changed = (i_level != r_stable);
    assign w_elapsed = w_changed ? '0 : (i_now_ms - r_mark);

    always_comb begin
        o_res.level = i_level;
        o_res.fire  = w_changed && w_low;
        o_res.held  = 1'b0;
        n_long      = w_changed ? 1'b0 : r_long;
        n_mark      = (w_changed && w_low) ? i_now_ms : r_mark;
        if (w_low && i_enable) begin
            if (!n_long) begin
                if (w_elapsed >= kplrs_pkg::TIME_W'(i_long_press_ms)) begin
                    n_long     = 1'b1;
                    n_mark     = i_now_ms;
                    o_res.fire = 1'b1;
                    o_res.held = 1'b1;
                end
            end else if (w_elapsed >= kplrs_pkg::TIME_W'(i_repeat_interval_ms)) begin
                n_mark     = i_now_ms;
                o_res.fire = 1'b1;
                o_res.held = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable <= 1'b1;
            r_long   <= 1'b0;
            r_mark   <= '0;
        end else if (i_step) begin
            r_stable <= i_level;
            r_long   <= n_long;
            r_mark   <= n_mark;
        end
    end

endmodule

/* hdl/key_press_long_repeat_scanner_top.sv */
// ----------------------------------------------------------------------------
// key_press_long_repeat_scanner_top
// Key scanner with press detection, long press and auto-repeat.
// ----------------------------------------------------------------------------
// Each accepted scan yields one result. The block takes one scan per clock
// cycle while its results are taken. An accepted scan is held in the input
// register, then the per-key compare and subtract lands in the result
// register. While a result waits to be taken, one further scan can still
// enter the input register; after that the input stalls until the result is
// transferred. Register writes take effect in the cycle after their transfer
// and are always accepted.
module key_press_long_repeat_scanner_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    kplrs_in_if.sink      i_in,
    kplrs_out_if.source   o_res,
    kplrs_cfg_if.sink     i_cfg
);

    localparam int NK = kplrs_pkg::NUM_KEYS;

    kplrs_pkg::t_cfg              w_cfg;
    kplrs_pkg::t_key_res          w_key [NK];
    logic                         r_in_valid;
    logic [NK-1:0]                r_key_levels;
    logic [kplrs_pkg::TIME_W-1:0] r_now_ms;
    logic                         r_out_valid;
    logic [NK-1:0]                r_press;
    logic [NK-1:0]                r_held;
    logic [NK-1:0]                r_stable;
    logic [NK-1:0]                w_fire;
    logic [NK-1:0]                w_held;
    logic [NK-1:0]                w_level;
    logic                         w_advance;

    kplrs_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    assign w_advance  = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_in.ready = !r_in_valid || w_advance;

    for (genvar k = 0; k < NK; k++) begin : g_key
        kplrs_key_cell u_key_cell (
            .i_clk                (i_clk),
            .i_rst_n              (i_rst_n),
            .i_step               (w_advance),
            .i_level              (r_key_levels[k]),
            .i_now_ms             (r_now_ms),
            .i_enable             (w_cfg.repeat_enable_mask[k]),
            .i_long_press_ms      (w_cfg.long_press_ms),
            .i_repeat_interval_ms (w_cfg.repeat_interval_ms),
            .o_res                (w_key[k])
        );
        assign w_fire[k]  = w_key[k].fire;
        assign w_held[k]  = w_key[k].held;
        assign w_level[k] = w_key[k].level;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_key_levels <= i_in.key_levels;
            r_now_ms     <= i_in.now_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_press  <= w_fire;
            r_held   <= w_held;
            r_stable <= w_level;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.press_mask     = r_press;
    assign o_res.held_fire_mask = r_held;
    assign o_res.stable_levels  = r_stable;

endmodule

/* hdl/kplrs_checker.sv */
// ----------------------------------------------------------------------------
// kplrs_checker
// Port-level checks on the scanner result channel.
// ----------------------------------------------------------------------------
module kplrs_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic [kplrs_pkg::NUM_KEYS-1:0] i_press_mask,
    input logic [kplrs_pkg::NUM_KEYS-1:0] i_held_fire_mask,
    input logic [kplrs_pkg::NUM_KEYS-1:0] i_stable_levels
);

    // A long-press or repeat fire is always also a fire.
    a_held_in_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((i_held_fire_mask & ~i_press_mask) == '0))
        else $error("held fire without press");

    // A key can only fire while it is held down.
    a_fire_when_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((i_press_mask & i_stable_levels) == '0))
        else $error("fire on a released key");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_press_mask)
            && $stable(i_held_fire_mask) && $stable(i_stable_levels)))
        else $error("stalled result changed");

endmodule

bind key_press_long_repeat_scanner_top kplrs_checker u_kplrs_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_res.valid),
    .i_out_ready      (o_res.ready),
    .i_press_mask     (o_res.press_mask),
    .i_held_fire_mask (o_res.held_fire_mask),
    .i_stable_levels  (o_res.stable_levels)
);
